// ----- rtl/hpfr_pkg.sv -----
package hpfr_pkg;

  localparam int unsigned COUNTER_WIDTH_DEF = 16;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned APB_AW            = 5;
  localparam int unsigned APB_DW            = 32;

  localparam logic [7:0] HDR_A = 8'h71;
  localparam logic [7:0] HDR_B = 8'h31;
  localparam logic [7:0] HDR_C = 8'hF1;
  localparam logic [8:0] LEN_EXTRA = 9'd3;

  localparam logic [8:0] MAX_SIZE_RST  = 9'd255;
  localparam logic [8:0] NORM_SIZE_RST = 9'd203;
  localparam logic [8:0] OPT_SIZE_RST  = 9'd20;
  localparam logic [7:0] NORM_CODE_RST = 8'd16;
  localparam logic [7:0] EXTRA_CODE_RST = 8'd33;

  typedef enum logic [2:0] {
    REG_MAX_SIZE   = 3'd0,
    REG_NORM_SIZE  = 3'd1,
    REG_OPT_SIZE   = 3'd2,
    REG_NORM_CODE  = 3'd3,
    REG_EXTRA_CODE = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    EV_BUSY       = 3'd0,
    EV_BAD_HEADER = 3'd1,
    EV_BAD_CSUM   = 3'd2,
    EV_OVERLONG   = 3'd3,
    EV_NORMAL     = 3'd4,
    EV_EXTRA      = 3'd5,
    EV_OPTIONAL   = 3'd6,
    EV_OTHER      = 3'd7
  } frame_event_e;

  typedef struct packed {
    logic [8:0] max_size;
    logic [8:0] norm_size;
    logic [8:0] opt_size;
    logic [7:0] norm_code;
    logic [7:0] extra_code;
  } cfg_t;

  // one classified byte on its way to the back end
  typedef struct packed {
    logic [7:0]   data;
    logic [8:0]   pos;
    frame_event_e ev;
  } q_item_t;

endpackage

// ----- rtl/heat_pump_frame_receiver_core.sv -----
// Channel   Direction  Handshake               Payload
// rx        in         push / full             rx_byte_i
// result    out        empty / pop             byte_echo_o ... bad_checksum_count_o
// config    in         APB psel/penable/pwrite paddr[4:2] selects register, pwdata
//
// One byte per cycle sustained while the result side keeps popping; a byte reaches the
// result ports via the front classifier, a 2-entry queue and the back-end output register.
// The front end tracks frame position and checksum; the back end holds counters.
// Reset clears all frame state, counters and the sticky flag; config regs reload.
// A stalled result output holds the back end; the queue then fills and raises full.
module heat_pump_frame_receiver_core import hpfr_pkg::*; #(
  parameter int unsigned COUNTER_WIDTH = COUNTER_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        rx_byte_i,
  output logic              empty,
  input  logic              pop,
  output logic [7:0]        byte_echo_o,
  output logic [8:0]        byte_position_o,
  output logic [2:0]        frame_event_o,
  output logic              extra_seen_o,
  output logic [15:0]       total_count_o,
  output logic [15:0]       good_count_o,
  output logic [15:0]       bad_header_count_o,
  output logic [15:0]       bad_checksum_count_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  cfg_t     cfg_q;
  logic     cfg_wr;
  reg_idx_e reg_idx;
  logic     q_push, q_full, q_pop, q_empty;
  q_item_t  q_in, q_out;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_size   <= MAX_SIZE_RST;
      cfg_q.norm_size  <= NORM_SIZE_RST;
      cfg_q.opt_size   <= OPT_SIZE_RST;
      cfg_q.norm_code  <= NORM_CODE_RST;
      cfg_q.extra_code <= EXTRA_CODE_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_MAX_SIZE:   cfg_q.max_size   <= pwdata[8:0];
        REG_NORM_SIZE:  cfg_q.norm_size  <= pwdata[8:0];
        REG_OPT_SIZE:   cfg_q.opt_size   <= pwdata[8:0];
        REG_NORM_CODE:  cfg_q.norm_code  <= pwdata[7:0];
        REG_EXTRA_CODE: cfg_q.extra_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MAX_SIZE:   prdata = APB_DW'(cfg_q.max_size);
      REG_NORM_SIZE:  prdata = APB_DW'(cfg_q.norm_size);
      REG_OPT_SIZE:   prdata = APB_DW'(cfg_q.opt_size);
      REG_NORM_CODE:  prdata = APB_DW'(cfg_q.norm_code);
      REG_EXTRA_CODE: prdata = APB_DW'(cfg_q.extra_code);
      default:        prdata = '0;
    endcase
  end

  assign full = q_full;

  hpfr_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (rx_byte_i),
    .cfg_i    (cfg_q),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_item_o (q_in)
  );

  hpfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .item_o  (q_out),
    .empty_o (q_empty)
  );

  hpfr_back #(
    .CNT_W (COUNTER_WIDTH)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .q_empty_i            (q_empty),
    .q_item_i             (q_out),
    .q_pop_o              (q_pop),
    .pop_i                (pop),
    .empty_o              (empty),
    .byte_echo_o          (byte_echo_o),
    .byte_position_o      (byte_position_o),
    .frame_event_o        (frame_event_o),
    .extra_seen_o         (extra_seen_o),
    .total_count_o        (total_count_o),
    .good_count_o         (good_count_o),
    .bad_header_count_o   (bad_header_count_o),
    .bad_checksum_count_o (bad_checksum_count_o)
  );

`ifndef SYNTHESIS
  a_push_not_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_bad_hdr_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_event_o == EV_BAD_HEADER) |-> (byte_position_o == 9'd0))
    else $error("bad header reported away from frame start");

  a_extra_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && frame_event_o == EV_EXTRA) |-> extra_seen_o)
    else $error("extra frame without sticky flag");
`endif

endmodule

// ----- rtl/hpfr_front.sv -----
module hpfr_front import hpfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  logic [7:0] data_i,
  input  cfg_t       cfg_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output q_item_t    q_item_o
);

  logic [8:0] cnt_q, cnt_d;
  logic [7:0] sum_q, sum_d;
  logic [8:0] len_q, len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] sum_n;
  logic [8:0] cnt_n;
  logic [8:0] len_n;
  logic       hdr_ok;
  frame_event_e ev;

  function automatic frame_event_e classify(input logic [8:0] len,
                                            input logic [7:0] tb,
                                            input cfg_t       cfg);
    frame_event_e res;
    if (len == cfg.norm_size) begin
      if (tb == cfg.norm_code) begin
        res = EV_NORMAL;
      end else if (tb == cfg.extra_code) begin
        res = EV_EXTRA;
      end else begin
        res = EV_OTHER;
      end
    end else if (len == cfg.opt_size) begin
      res = EV_OPTIONAL;
    end else begin
      res = EV_OTHER;
    end
    return res;
  endfunction

  assign q_push_o = push_i && !q_full_i;
  assign hdr_ok   = (data_i == HDR_A) || (data_i == HDR_B) || (data_i == HDR_C);
  assign sum_n    = sum_q + data_i;
  assign cnt_n    = cnt_q + 9'd1;
  assign len_n    = {1'b0, data_i} + LEN_EXTRA;

  always_comb begin
    cnt_d  = cnt_q;
    sum_d  = sum_q;
    len_d  = len_q;
    type_d = type_q;
    ev     = EV_BUSY;
    if (cnt_q == 9'd0) begin
      if (!hdr_ok) begin
        ev = EV_BAD_HEADER;
      end else begin
        sum_d  = data_i;
        type_d = 8'd0;
        cnt_d  = 9'd1;
      end
    end else begin
      sum_d = sum_n;
      if (cnt_q == 9'd1) begin
        len_d = len_n;
        if (len_n > cfg_i.max_size) begin
          ev    = EV_OVERLONG;
          cnt_d = 9'd0;
        end else begin
          cnt_d = 9'd2;
        end
      end else begin
        if (cnt_q == 9'd3) begin
          type_d = data_i;
        end
        cnt_d = cnt_n;
        if (cnt_n == len_q) begin
          // last byte: sum over the whole frame must come out zero
          if (sum_n != 8'd0) begin
            ev = EV_BAD_CSUM;
          end else begin
            ev = classify(len_q, type_d, cfg_i);
          end
          cnt_d = 9'd0;
        end
      end
    end
  end

  assign q_item_o = '{data: data_i, pos: cnt_q, ev: ev};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      sum_q  <= '0;
      len_q  <= '0;
      type_q <= '0;
    end else if (q_push_o) begin
      cnt_q  <= cnt_d;
      sum_q  <= sum_d;
      len_q  <= len_d;
      type_q <= type_d;
    end
  end

endmodule

// ----- rtl/hpfr_queue.sv -----
module hpfr_queue import hpfr_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output q_item_t item_o,
  output logic    empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  q_item_t            mem_q [DEPTH];
  logic [PTR_W-1:0]   wr_q, rd_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rd_q];

  function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= nxt(wr_q);
      end
      if (do_pop) begin
        rd_q <= nxt(rd_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ----- rtl/hpfr_back.sv -----
module hpfr_back import hpfr_pkg::*; #(
  parameter int unsigned CNT_W = COUNTER_WIDTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  q_item_t     q_item_i,
  output logic        q_pop_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [7:0]  byte_echo_o,
  output logic [8:0]  byte_position_o,
  output logic [2:0]  frame_event_o,
  output logic        extra_seen_o,
  output logic [15:0] total_count_o,
  output logic [15:0] good_count_o,
  output logic [15:0] bad_header_count_o,
  output logic [15:0] bad_checksum_count_o
);

  logic             vld_q;
  q_item_t          out_q;
  logic             extra_q;
  logic [CNT_W-1:0] total_q, good_q, bad_hdr_q, bad_sum_q;
  logic             is_good;

  // output slot frees on the same edge it is taken, so one transfer per cycle
  assign q_pop_o = !q_empty_i && (!vld_q || pop_i);
  assign is_good = q_item_i.ev inside {EV_NORMAL, EV_EXTRA, EV_OPTIONAL, EV_OTHER};

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= q_item_i;
    end
  end

  // counters always match the item held in the output slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= 1'b0;
      extra_q   <= 1'b0;
      total_q   <= '0;
      good_q    <= '0;
      bad_hdr_q <= '0;
      bad_sum_q <= '0;
    end else begin
      if (q_pop_o) begin
        vld_q <= 1'b1;
        if (q_item_i.pos == 9'd0) begin
          total_q <= total_q + 1'b1;
        end
        if (q_item_i.ev == EV_BAD_HEADER) begin
          bad_hdr_q <= bad_hdr_q + 1'b1;
        end
        if (q_item_i.ev == EV_BAD_CSUM) begin
          bad_sum_q <= bad_sum_q + 1'b1;
        end
        if (is_good) begin
          good_q <= good_q + 1'b1;
        end
        if (q_item_i.ev == EV_EXTRA) begin
          extra_q <= 1'b1;
        end
      end else if (pop_i) begin
        vld_q <= 1'b0;
      end
    end
  end

  assign empty_o              = !vld_q;
  assign byte_echo_o          = out_q.data;
  assign byte_position_o      = out_q.pos;
  assign frame_event_o        = out_q.ev;
  assign extra_seen_o         = extra_q;
  assign total_count_o        = 16'(total_q);
  assign good_count_o         = 16'(good_q);
  assign bad_header_count_o   = 16'(bad_hdr_q);
  assign bad_checksum_count_o = 16'(bad_sum_q);

endmodule

// ----- tb/heat_pump_frame_receiver_core_tb.sv -----
module heat_pump_frame_receiver_core_tb import hpfr_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              push    = 1'b0;
  logic              full;
  logic [7:0]        rx_byte_i = '0;
  logic              empty;
  logic              pop     = 1'b0;
  logic [7:0]        byte_echo_o;
  logic [8:0]        byte_position_o;
  logic [2:0]        frame_event_o;
  logic              extra_seen_o;
  logic [15:0]       total_count_o;
  logic [15:0]       good_count_o;
  logic [15:0]       bad_header_count_o;
  logic [15:0]       bad_checksum_count_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [APB_AW-1:0] paddr   = '0;
  logic [APB_DW-1:0] pwdata  = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  heat_pump_frame_receiver_core u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .push                 (push),
    .full                 (full),
    .rx_byte_i            (rx_byte_i),
    .empty                (empty),
    .pop                  (pop),
    .byte_echo_o          (byte_echo_o),
    .byte_position_o      (byte_position_o),
    .frame_event_o        (frame_event_o),
    .extra_seen_o         (extra_seen_o),
    .total_count_o        (total_count_o),
    .good_count_o         (good_count_o),
    .bad_header_count_o   (bad_header_count_o),
    .bad_checksum_count_o (bad_checksum_count_o),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  typedef struct {
    logic [7:0]   echo;
    logic [8:0]   pos;
    frame_event_e ev;
    logic         extra;
    logic [15:0]  total;
    logic [15:0]  good;
    logic [15:0]  bad_hdr;
    logic [15:0]  bad_csum;
  } rx_result_t;

  rx_result_t echo_q[$];

  // shadow registers
  logic [8:0] cfg_max        = MAX_SIZE_RST;
  logic [8:0] cfg_norm       = NORM_SIZE_RST;
  logic [8:0] cfg_opt        = OPT_SIZE_RST;
  logic [7:0] cfg_norm_code  = NORM_CODE_RST;
  logic [7:0] cfg_extra_code = EXTRA_CODE_RST;

  // frame tracking state
  logic [8:0]  fr_pos   = '0;
  logic [7:0]  fr_sum   = '0;
  logic [8:0]  fr_len   = '0;
  logic [7:0]  fr_kind  = '0;
  logic        fr_extra = 1'b0;
  logic [15:0] n_total    = '0;
  logic [15:0] n_good     = '0;
  logic [15:0] n_bad_hdr  = '0;
  logic [15:0] n_bad_csum = '0;

  int ev_tally[8];
  int bytes_sent    = 0;
  int err_cnt       = 0;
  int quiet_cycles  = 0;
  int rx_stall_left = 0;
  bit tx_gaps_on    = 1'b0;
  bit rx_stall_on   = 1'b0;
  bit rx_hold       = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic frame_event_e classify_frame();
    if (fr_len == cfg_norm) begin
      if (fr_kind == cfg_norm_code) return EV_NORMAL;
      if (fr_kind == cfg_extra_code) begin
        fr_extra = 1'b1;
        return EV_EXTRA;
      end
      return EV_OTHER;
    end
    if (fr_len == cfg_opt) return EV_OPTIONAL;
    return EV_OTHER;
  endfunction

  function automatic void predict_frame_byte(logic [7:0] b);
    rx_result_t r;
    r.echo = b;
    r.pos  = fr_pos;
    r.ev   = EV_BUSY;
    if (fr_pos == 9'd0) begin
      n_total++;
      if (b != HDR_A && b != HDR_B && b != HDR_C) begin
        n_bad_hdr++;
        r.ev = EV_BAD_HEADER;
      end else begin
        fr_sum  = b;
        fr_kind = '0;
        fr_pos  = 9'd1;
      end
    end else begin
      fr_sum = fr_sum + b;
      if (fr_pos == 9'd1) begin
        // length is formed at 9 bits, no wrap
        fr_len = {1'b0, b} + LEN_EXTRA;
        if (fr_len > cfg_max) begin
          r.ev   = EV_OVERLONG;
          fr_pos = 9'd0;
        end else begin
          fr_pos = 9'd2;
        end
      end else begin
        if (fr_pos == 9'd3) fr_kind = b;
        fr_pos = fr_pos + 9'd1;
        if (fr_pos == fr_len) begin
          if (fr_sum != 8'd0) begin
            n_bad_csum++;
            r.ev = EV_BAD_CSUM;
          end else begin
            n_good++;
            r.ev = classify_frame();
          end
          fr_pos = 9'd0;
        end
      end
    end
    r.extra    = fr_extra;
    r.total    = n_total;
    r.good     = n_good;
    r.bad_hdr  = n_bad_hdr;
    r.bad_csum = n_bad_csum;
    ev_tally[r.ev]++;
    echo_q = {echo_q, r};
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // result side: check each transfer, then decide pop for the next edge
  always @(posedge clk_i) begin
    rx_result_t w;
    if (rst_ni && pop && !empty) begin
      if (echo_q.size() == 0) begin
        $error("result transfer with nothing pending, byte_echo 0x%0h", byte_echo_o);
        err_cnt++;
      end else begin
        w = echo_q.pop_front();
        check_field("byte_echo", w.echo, byte_echo_o);
        check_field("byte_position", w.pos, byte_position_o);
        check_field("frame_event", w.ev, frame_event_o);
        check_field("extra_seen", w.extra, extra_seen_o);
        check_field("total_count", w.total, total_count_o);
        check_field("good_count", w.good, good_count_o);
        check_field("bad_header_count", w.bad_hdr, bad_header_count_o);
        check_field("bad_checksum_count", w.bad_csum, bad_checksum_count_o);
      end
    end
    if (!rst_ni || rx_hold) begin
      pop <= 1'b0;
    end else if (!rx_stall_on) begin
      pop <= 1'b1;
    end else if (rx_stall_left > 0) begin
      pop <= 1'b0;
      rx_stall_left--;
    end else begin
      pop <= 1'b1;
      rx_stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (psel && penable)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("heat_pump_frame_receiver_core test failed");
      $finish;
    end
  end

  // push stays high after a transfer so back-to-back bytes need no toggle
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push      <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (full !== 1'b0);
    predict_frame_byte(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] hdr, input int len, input logic [7:0] kind,
                            input bit bad_sum, input int keep);
    logic [7:0] frame_bytes[$];
    logic [7:0] sum;
    logic [7:0] nxt_byte;
    int i;
    frame_bytes = {frame_bytes, hdr};
    frame_bytes = {frame_bytes, 8'(len - 3)};
    for (i = 2; i < len - 1; i++) begin
      nxt_byte    = (i == 3) ? kind : 8'($urandom);
      frame_bytes = {frame_bytes, nxt_byte};
    end
    sum = '0;
    foreach (frame_bytes[j]) sum += frame_bytes[j];
    nxt_byte    = bad_sum ? 8'(-sum + $urandom_range(1, 255)) : 8'(-sum);
    frame_bytes = {frame_bytes, nxt_byte};
    // an overlong frame is dropped after its length byte
    if (len > cfg_max && keep > 2) keep = 2;
    for (i = 0; i < keep; i++) send_byte(frame_bytes[i]);
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    while (echo_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input reg_idx_e idx, input logic [8:0] val);
    logic [APB_DW-1:0] data;
    data = $urandom();
    if (idx == REG_NORM_CODE || idx == REG_EXTRA_CODE) data[7:0] = val[7:0];
    else data[8:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= APB_AW'({idx, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_MAX_SIZE:   cfg_max        = data[8:0];
      REG_NORM_SIZE:  cfg_norm       = data[8:0];
      REG_OPT_SIZE:   cfg_opt        = data[8:0];
      REG_NORM_CODE:  cfg_norm_code  = data[7:0];
      REG_EXTRA_CODE: cfg_extra_code = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [8:0] max_size, input logic [8:0] norm_size,
                            input logic [8:0] opt_size, input logic [7:0] norm_code,
                            input logic [7:0] extra_code);
    wait_idle();
    reg_write(REG_MAX_SIZE, max_size);
    reg_write(REG_NORM_SIZE, norm_size);
    reg_write(REG_OPT_SIZE, opt_size);
    reg_write(REG_NORM_CODE, {1'b0, norm_code});
    reg_write(REG_EXTRA_CODE, {1'b0, extra_code});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  function automatic logic [7:0] pick_header();
    case ($urandom_range(0, 2))
      0:       return HDR_A;
      1:       return HDR_B;
      default: return HDR_C;
    endcase
  endfunction

  // mostly short frames; the configured sizes and overlong lengths now and then
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 12) return cfg_norm;
    if (r < 32) return cfg_opt;
    if (r < 42) return 3;
    if (r < 47) return cfg_max;
    if (r < 60 && cfg_max < 9'd258) return $urandom_range(cfg_max + 1, 258);
    return $urandom_range(3, (cfg_max < 9'd16) ? cfg_max : 16);
  endfunction

  function automatic logic [7:0] pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return cfg_norm_code;
    if (r < 70) return cfg_extra_code;
    return 8'($urandom);
  endfunction

  // reset values in place: rejected headers and lengths past the default limit
  task automatic test_header_rejects();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(HDR_A, 258, 8'h00, 1'b0, 2);
    send_frame(HDR_C, 256, 8'h00, 1'b0, 2);
  endtask

  task automatic test_frame_classes();
    set_config(MAX_SIZE_RST, 9'd5, 9'd4, NORM_CODE_RST, EXTRA_CODE_RST);
    send_frame(HDR_A, 5, cfg_norm_code, 1'b0, 5);
    send_frame(HDR_B, 5, cfg_extra_code, 1'b0, 5);
    send_frame(HDR_C, 4, 8'h00, 1'b0, 4);
    // three-byte frame: no type byte, classed as other good
    send_frame(HDR_A, 3, 8'h00, 1'b0, 3);
    send_frame(HDR_B, 3, 8'h00, 1'b1, 3);
  endtask

  // hold the result side until the queue fills, then let it drain
  task automatic test_backpressure();
    rx_hold = 1'b1;
    fork
      begin
        send_frame(HDR_A, 5, cfg_norm_code, 1'b0, 5);
        send_frame(HDR_C, 4, 8'h00, 1'b0, 4);
        send_frame(HDR_B, 3, 8'h00, 1'b0, 3);
      end
      begin
        repeat (30) @(posedge clk_i);
        @(negedge clk_i) rx_hold = 1'b0;
      end
    join
    wait_idle();
  endtask

  task automatic run_random_traffic(input int n_items);
    int start;
    int len;
    int keep;
    bit paused;
    start  = bytes_sent;
    paused = 1'b0;
    while (bytes_sent - start < n_items) begin
      if (!paused && bytes_sent - start >= n_items / 2) begin
        wait_idle();
        paused = 1'b1;
      end
      if ($urandom_range(0, 99) < 3) begin
        tx_gaps_on  = ($urandom_range(0, 3) != 0);
        rx_stall_on = ($urandom_range(0, 3) != 0);
      end
      if ($urandom_range(0, 99) < 15) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
      end else begin
        len  = pick_len();
        keep = len;
        if ($urandom_range(0, 99) < 5) keep = $urandom_range(1, len - 1);
        send_frame(pick_header(), len, pick_kind(), ($urandom_range(0, 99) < 15), keep);
      end
    end
  endtask

  task automatic test_config_sweep();
    tx_gaps_on  = 1'b1;
    rx_stall_on = 1'b1;
    set_config(9'd40, 9'd8, 9'd6, 8'd16, 8'd33);
    run_random_traffic(400);
    set_config(9'd258, 9'd258, 9'd4, 8'h00, 8'hFF);
    run_random_traffic(450);
    set_config(9'd4, 9'd4, 9'd5, 8'hFF, 8'h00);
    run_random_traffic(350);
    set_config(9'($urandom_range(4, 258)), 9'($urandom_range(4, 20)),
               9'($urandom_range(4, 20)), 8'($urandom), 8'($urandom));
    run_random_traffic(400);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_header_rejects();
    test_frame_classes();
    test_backpressure();
    test_config_sweep();
    wait_idle();
    $display("covered %0d bytes: %0d bad headers, %0d overlong, %0d bad checksums",
             bytes_sent, ev_tally[EV_BAD_HEADER], ev_tally[EV_OVERLONG],
             ev_tally[EV_BAD_CSUM]);
    $display("good frames: %0d normal, %0d extra, %0d optional, %0d other",
             ev_tally[EV_NORMAL], ev_tally[EV_EXTRA], ev_tally[EV_OPTIONAL],
             ev_tally[EV_OTHER]);
    if (err_cnt == 0) begin
      $display("heat_pump_frame_receiver_core test passed");
    end else begin
      $display("heat_pump_frame_receiver_core test failed");
    end
    $finish;
  end

endmodule
